// File: hdl/assert_macros.svh
// Shared assertion forms for the thermostat checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AHT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define AHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/aht_pkg.sv
package aht_pkg;

  localparam int AVG_COUNT_DEF = 8;
  localparam int SUM_W         = 14;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int TEMP_W        = 8;

  localparam logic [CFG_W-1:0]  RESET_SET_TEMP  = 7'd60;
  localparam logic [CFG_W-1:0]  RESET_HEAT_TOL  = 7'd5;
  localparam logic [CFG_W-1:0]  RESET_COOL_TOL  = 7'd5;
  localparam logic [TEMP_W-1:0] RESET_AVERAGE   = 8'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_TEMP = 2'd0,
    REG_HEAT_TOL = 2'd1,
    REG_COOL_TOL = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LAMP_OFF   = 2'd0,
    LAMP_ON    = 2'd1,
    LAMP_BLINK = 2'd2
  } lamp_mode_t;

  typedef struct packed {
    logic              enable;
    logic              sample_valid;
    logic [TEMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                     heater_on;
    logic                     cooler_on;
    logic [1:0]               lamp_mode;
    logic [TEMP_W-1:0]        average_temperature;
    logic signed [TEMP_W-1:0] temperature_error;
    logic                     average_done;
  } out_item_t;

endpackage

// File: hdl/aht_in_reg.sv
module aht_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  aht_pkg::in_item_t in_data,
  input  logic             out_ready,
  output logic             adv,
  output aht_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  aht_pkg::in_item_t data_r;
  logic              take;

  assign adv      = valid_r && out_ready;
  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;
  assign item     = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

endmodule

// File: hdl/aht_core.sv
module aht_core #(
  parameter int AVG_COUNT = aht_pkg::AVG_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aht_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          adv,
  input  aht_pkg::in_item_t             item,
  output aht_pkg::out_item_t            res
);

  localparam int CNT_W   = $clog2(AVG_COUNT + 1);
  localparam int SHIFT   = aht_pkg::SUM_W + $clog2(AVG_COUNT);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = aht_pkg::SUM_W + RECIP_W;
  localparam longint RECIP = ((64'd1 << SHIFT) + AVG_COUNT - 1) / AVG_COUNT;

  logic [aht_pkg::CFG_W-1:0]  set_temp_r;
  logic [aht_pkg::CFG_W-1:0]  heat_tol_r;
  logic [aht_pkg::CFG_W-1:0]  cool_tol_r;

  logic [aht_pkg::SUM_W-1:0]  sum_r,      sum_nxt;
  logic [CNT_W-1:0]           left_r,     left_nxt;
  logic                       heater_r,   heater_nxt;
  logic                       cooler_r,   cooler_nxt;
  aht_pkg::lamp_mode_t        lamp_r,     lamp_nxt;
  logic [aht_pkg::TEMP_W-1:0] avg_r,      avg_nxt;
  logic signed [aht_pkg::TEMP_W-1:0] err_r, err_nxt;

  logic [aht_pkg::SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]           left_acc;
  logic                       done;
  logic [PROD_W-1:0]          prod;
  logic [aht_pkg::TEMP_W-1:0] avg_new;
  logic signed [9:0]          diff;
  logic signed [aht_pkg::TEMP_W-1:0] err_new;
  logic signed [8:0]          err_ext;
  logic signed [8:0]          heat_ext;
  logic signed [8:0]          cool_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_temp_r <= aht_pkg::RESET_SET_TEMP;
      heat_tol_r <= aht_pkg::RESET_HEAT_TOL;
      cool_tol_r <= aht_pkg::RESET_COOL_TOL;
    end else if (cfg_we) begin
      case (aht_pkg::cfg_reg_t'(cfg_index))
        aht_pkg::REG_SET_TEMP: set_temp_r <= cfg_wdata;
        aht_pkg::REG_HEAT_TOL: heat_tol_r <= cfg_wdata;
        aht_pkg::REG_COOL_TOL: cool_tol_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_acc  = sum_r;
    left_acc = left_r;
    if (item.sample_valid) begin
      sum_acc = sum_r + aht_pkg::SUM_W'(item.sample);
      if (left_r != '0) begin
        left_acc = left_r - CNT_W'(1);
      end
    end
    done = item.enable && (left_acc == '0);

    // average by reciprocal multiply, exact for every 14-bit sum
    prod    = PROD_W'(sum_acc) * PROD_W'(RECIP);
    avg_new = prod[SHIFT +: aht_pkg::TEMP_W];

    diff = $signed({2'b00, avg_new}) - $signed({3'b000, set_temp_r});
    if (diff > 10'sd127) begin
      err_new = 8'sd127;
    end else begin
      err_new = diff[aht_pkg::TEMP_W-1:0];
    end

    err_ext  = {err_new[aht_pkg::TEMP_W-1], err_new};
    heat_ext = $signed({2'b00, heat_tol_r});
    cool_neg = -$signed({2'b00, cool_tol_r});
  end

  always_comb begin
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    heater_nxt = heater_r;
    cooler_nxt = cooler_r;
    lamp_nxt   = lamp_r;
    avg_nxt    = avg_r;
    err_nxt    = err_r;
    if (!item.enable) begin
      heater_nxt = 1'b0;
      cooler_nxt = 1'b0;
      lamp_nxt   = aht_pkg::LAMP_OFF;
    end else if (done) begin
      sum_nxt  = '0;
      left_nxt = CNT_W'(AVG_COUNT);
      avg_nxt  = avg_new;
      err_nxt  = err_new;
      if (err_ext >= heat_ext) begin
        if (!heater_r) begin
          cooler_nxt = 1'b1;
          lamp_nxt   = aht_pkg::LAMP_ON;
        end else begin
          heater_nxt = 1'b0;
        end
      end else if (err_ext <= cool_neg) begin
        if (!cooler_r) begin
          heater_nxt = 1'b1;
          lamp_nxt   = aht_pkg::LAMP_BLINK;
        end else begin
          cooler_nxt = 1'b0;
        end
      end
    end else begin
      sum_nxt  = sum_acc;
      left_nxt = left_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      left_r   <= CNT_W'(AVG_COUNT);
      heater_r <= 1'b0;
      cooler_r <= 1'b0;
      lamp_r   <= aht_pkg::LAMP_OFF;
      avg_r    <= aht_pkg::RESET_AVERAGE;
      err_r    <= '0;
    end else if (adv) begin
      sum_r    <= sum_nxt;
      left_r   <= left_nxt;
      heater_r <= heater_nxt;
      cooler_r <= cooler_nxt;
      lamp_r   <= lamp_nxt;
      avg_r    <= avg_nxt;
      err_r    <= err_nxt;
    end
  end

  always_comb begin
    res.heater_on           = heater_nxt;
    res.cooler_on           = cooler_nxt;
    res.lamp_mode           = lamp_nxt;
    res.average_temperature = avg_nxt;
    res.temperature_error   = err_nxt;
    res.average_done        = done;
  end

endmodule

// File: hdl/aht_out_reg.sv
module aht_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  aht_pkg::out_item_t res,
  output logic               out_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output aht_pkg::out_item_t out_data
);

  logic               valid_r;
  logic               valid_nxt;
  aht_pkg::out_item_t data_r;

  assign out_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

// File: hdl/averaging_hysteresis_thermostat.sv
// Averaging thermostat with a dead band on heater, cooler and lamp.
// Input channel in_valid/in_stall/in_data: one control tick per transfer,
// carrying enable, sample_valid and an 8-bit temperature sample.
// Output channel out_valid/out_stall/out_data: exactly one result per tick,
// in order: heater, cooler, lamp mode, latest average, latest error and
// a flag that marks the tick on which a new average was formed.
// Configuration: cfg_we with cfg_index 0 set point, 1 heat tolerance,
// 2 cool tolerance; other indexes are ignored. Write only while idle.
// Path: a tick passes through the input register, then the result register.
// Throughput: one tick per cycle while the output is not stalled; the state
// update for a tick happens in the single step between the two registers,
// so the next tick sees it straight away.
// Stall: a stalled result holds in the result register; the input register
// keeps taking ticks until it is itself full, then in_stall rises.
// Reset (synchronous, rst_n low): both channels empty, sum cleared, count
// reloaded, heater, cooler and lamp off, average 30, error 0, and the
// registers back to 60, 5 and 5.
module averaging_hysteresis_thermostat #(
  parameter int AVG_COUNT = aht_pkg::AVG_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aht_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output aht_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [aht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aht_pkg::CFG_W-1:0]     cfg_wdata
);

  logic               out_ready;
  logic               adv;
  aht_pkg::in_item_t  item;
  aht_pkg::out_item_t res;

  aht_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_ready (out_ready),
    .adv       (adv),
    .item      (item)
  );

  aht_core #(
    .AVG_COUNT (AVG_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .item      (item),
    .res       (res)
  );

  aht_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hdl/aht_checker.sv
`include "assert_macros.svh"

module aht_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input aht_pkg::out_item_t out_data
);

  `AHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `AHT_ASSERT_SAME(a_not_both, clk, rst_n, out_valid, !(out_data.heater_on && out_data.cooler_on), "heater and cooler both on")
  `AHT_ASSERT_SAME(a_heat_lamp, clk, rst_n, out_valid && out_data.heater_on, out_data.lamp_mode == aht_pkg::LAMP_BLINK, "heater on without blink")
  `AHT_ASSERT_SAME(a_cool_lamp, clk, rst_n, out_valid && out_data.cooler_on, out_data.lamp_mode == aht_pkg::LAMP_ON, "cooler on without lamp")

endmodule

bind averaging_hysteresis_thermostat aht_checker u_aht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/thermostat_checker.sv
`timescale 1ns / 1ps
module thermostat_checker
  import aht_pkg::*;
#(
  parameter int AVG_COUNT = AVG_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   failures,
  output int                   outstanding
);

  localparam int PRINT_LIMIT = 100;

  logic [CFG_W-1:0]         set_point;
  logic [CFG_W-1:0]         heat_tol;
  logic [CFG_W-1:0]         cool_tol;
  logic [SUM_W-1:0]         sum_acc;
  int                       samples_to_go;
  logic                     heater;
  logic                     cooler;
  lamp_mode_t               lamp;
  logic [TEMP_W-1:0]        avg_temp;
  logic signed [TEMP_W-1:0] avg_error;
  out_item_t                awaited_controls[$];
  int                       mismatch_total = 0;
  int                       awaited_count = 0;

  assign failures    = mismatch_total;
  assign outstanding = awaited_count;

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_total++;
    if (mismatch_total <= PRINT_LIMIT) begin
      $display("%0t ns thermostat %s: got %0d, want %0d", $time, field, got, want);
    end
  endtask

  task automatic step_thermostat(input in_item_t t);
    out_item_t r;
    int        diff;
    logic      done;
    done = 1'b0;
    if (t.enable) begin
      if (t.sample_valid) begin
        sum_acc = sum_acc + SUM_W'(t.sample);
        if (samples_to_go > 0) samples_to_go--;
      end
      if (samples_to_go == 0) begin
        samples_to_go = AVG_COUNT;
        avg_temp = TEMP_W'(sum_acc / AVG_COUNT);
        sum_acc = '0;
        diff = int'(avg_temp) - int'(set_point);
        if (diff > 127) diff = 127;
        if (diff < -128) diff = -128;
        avg_error = diff[TEMP_W-1:0];
        if (diff >= int'(heat_tol)) begin
          if (!heater) begin
            cooler = 1'b1;
            lamp = LAMP_ON;
          end else begin
            heater = 1'b0;
          end
        end else if (diff <= -int'(cool_tol)) begin
          if (!cooler) begin
            heater = 1'b1;
            lamp = LAMP_BLINK;
          end else begin
            cooler = 1'b0;
          end
        end
        done = 1'b1;
      end
    end else begin
      heater = 1'b0;
      cooler = 1'b0;
      lamp = LAMP_OFF;
    end
    r.heater_on = heater;
    r.cooler_on = cooler;
    r.lamp_mode = lamp;
    r.average_temperature = avg_temp;
    r.temperature_error = avg_error;
    r.average_done = done;
    awaited_controls.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      set_point = RESET_SET_TEMP;
      heat_tol = RESET_HEAT_TOL;
      cool_tol = RESET_COOL_TOL;
      sum_acc = '0;
      samples_to_go = AVG_COUNT;
      heater = 1'b0;
      cooler = 1'b0;
      lamp = LAMP_OFF;
      avg_temp = RESET_AVERAGE;
      avg_error = '0;
      awaited_controls.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_controls.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = awaited_controls.pop_front();
          if (out_data.heater_on !== want.heater_on)
            report_mismatch("heater_on", out_data.heater_on, want.heater_on);
          if (out_data.cooler_on !== want.cooler_on)
            report_mismatch("cooler_on", out_data.cooler_on, want.cooler_on);
          if (out_data.lamp_mode !== want.lamp_mode)
            report_mismatch("lamp_mode", out_data.lamp_mode, want.lamp_mode);
          if (out_data.average_temperature !== want.average_temperature)
            report_mismatch("average_temperature", out_data.average_temperature,
                            want.average_temperature);
          if (out_data.temperature_error !== want.temperature_error)
            report_mismatch("temperature_error", int'(out_data.temperature_error),
                            int'(want.temperature_error));
          if (out_data.average_done !== want.average_done)
            report_mismatch("average_done", out_data.average_done, want.average_done);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SET_TEMP: set_point = cfg_wdata;
          REG_HEAT_TOL: heat_tol = cfg_wdata;
          REG_COOL_TOL: cool_tol = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) step_thermostat(in_data);
    end
    awaited_count <= awaited_controls.size();
  end

endmodule

// File: tb/sv/tb_averaging_hysteresis_thermostat.sv
`timescale 1ns / 1ps
module tb_averaging_hysteresis_thermostat;
  import aht_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES     = 60;
  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 210;
  localparam int CALM_PHASE      = 3;
  localparam int PRESSURE_PHASE  = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   failures;
  int                   outstanding;

  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  logic rx_calm = 1'b0;
  int   stall_left = 0;

  always #1 clk = ~clk;

  averaging_hysteresis_thermostat dut (.*);

  thermostat_checker u_checker (.*);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      stall_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_calm || $urandom_range(0, 9) < 7) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 2);
    end
  end

  initial begin
    #2_000_000;
    $display("averaging_hysteresis_thermostat: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [CFG_W-1:0] pick_level(input int typical_max);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return CFG_W'($urandom_range(0, typical_max));
    return CFG_W'($urandom_range(0, 127));
  endfunction

  function automatic in_item_t make_tick(input int centre, input int spread);
    in_item_t t;
    int       s;
    t.enable = ($urandom_range(0, 99) >= 4);
    t.sample_valid = ($urandom_range(0, 99) >= 12);
    if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 255);
    else s = centre - spread + int'($urandom_range(0, 2 * spread));
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    t.sample = s[TEMP_W-1:0];
    return t;
  endfunction

  task automatic send_tick(input in_item_t t, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int               p;
    int               n;
    int               k;
    int               centre;
    int               offset;
    logic             calm;
    logic [CFG_W-1:0] sp;
    logic [CFG_W-1:0] ht;
    logic [CFG_W-1:0] ct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // full-scale average saturates the error, then disable forces all off
    for (k = 0; k < 8; k++) send_tick('{enable: 1'b1, sample_valid: 1'b1, sample: 8'hFF}, 0);
    send_tick('{enable: 1'b0, sample_valid: 1'b1, sample: 8'hFF}, 0);
    send_tick('{enable: 1'b1, sample_valid: 1'b0, sample: 8'h55}, 0);
    send_tick('{enable: 1'b1, sample_valid: 1'b0, sample: 8'hAA}, 0);
    for (k = 0; k < 8; k++) send_tick('{enable: 1'b1, sample_valid: 1'b1, sample: 8'h00}, 0);
    for (k = 0; k < 4; k++) send_tick('{enable: 1'b1, sample_valid: 1'b1, sample: 8'd200}, 0);
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          sp = '0;
          ht = '0;
          ct = '0;
        end
        1: begin
          sp = '1;
          ht = '1;
          ct = '1;
        end
        default: begin
          sp = pick_level(99);
          ht = pick_level(15);
          ct = pick_level(15);
        end
      endcase
      write_reg(REG_SET_TEMP, sp);
      write_reg(REG_HEAT_TOL, ht);
      write_reg(REG_COOL_TOL, ct);
      write_reg(REG_SPARE, CFG_W'($urandom_range(0, 127)));
      calm = (p == CALM_PHASE);
      rx_calm <= calm;
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      n = 0;
      while (n < TICKS_PER_PHASE) begin
        offset = int'($urandom_range(0, int'(ht) + int'(ct) + 16)) - (int'(ct) + 8);
        centre = int'(sp) + offset;
        for (k = 0; k < 8 && n < TICKS_PER_PHASE; k++) begin
          send_tick(make_tick(centre, 3), (calm || p == PRESSURE_PHASE) ? 0 : pick_gap());
          n++;
        end
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("averaging_hysteresis_thermostat: match");
    end else begin
      $display("averaging_hysteresis_thermostat: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/aht_pkg.sv
hdl/aht_in_reg.sv
hdl/aht_core.sv
hdl/aht_out_reg.sv
hdl/averaging_hysteresis_thermostat.sv
hdl/aht_checker.sv
tb/sv/thermostat_checker.sv
tb/sv/tb_averaging_hysteresis_thermostat.sv
